FILE: src/clt_pkg.sv
package clt_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxTokenLenDef = 255;
  localparam int unsigned PosBitsDef     = 32;

  // Token kinds
  localparam logic [3:0] KindInt    = 4'd0;
  localparam logic [3:0] KindFloat  = 4'd1;
  localparam logic [3:0] KindIdent  = 4'd2;
  localparam logic [3:0] KindFdecl  = 4'd3;
  localparam logic [3:0] KindIdecl  = 4'd4;
  localparam logic [3:0] KindPrint  = 4'd5;
  localparam logic [3:0] KindAssign = 4'd6;
  localparam logic [3:0] KindPlus   = 4'd7;
  localparam logic [3:0] KindMinus  = 4'd8;
  localparam logic [3:0] KindMul    = 4'd9;
  localparam logic [3:0] KindDiv    = 4'd10;
  localparam logic [3:0] KindEnd    = 4'd11;
  localparam logic [3:0] KindError  = 4'd12;

  // Error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrInvalid = 2'd1;
  localparam logic [1:0] ErrPoint   = 2'd2;
  localparam logic [1:0] ErrLong    = 2'd3;

  // Characters of interest
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChI      = 8'h69;
  localparam logic [7:0] ChP      = 8'h70;
  localparam logic [7:0] ChAssign = 8'h3D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChMul    = 8'h2A;
  localparam logic [7:0] ChDiv    = 8'h2F;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] Ch0      = 8'h30;
  localparam logic [7:0] Ch9      = 8'h39;
  localparam logic [7:0] ChA      = 8'h61;
  localparam logic [7:0] ChZ      = 8'h7A;

  // One result word
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] start;
    logic [7:0]  length;
    logic [1:0]  err;
    logic [7:0]  bad;
    logic        last;
  } tok_t;

  // Words produced for one source word: count, then up to two words in order
  typedef struct packed {
    logic [1:0] n;
    tok_t       w0;
    tok_t       w1;
  } push_t;

  function automatic tok_t make_tok(logic [3:0] kind, logic [31:0] start,
                                    logic [7:0] length, logic [1:0] err,
                                    logic [7:0] bad);
    tok_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    t.err    = err;
    t.bad    = bad;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

FILE: src/clt_if.sv
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface clt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [31:0] token_start;
  logic [7:0]  token_length;
  logic [1:0]  error_code;
  logic [7:0]  bad_char;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output error_code, output bad_char,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input error_code, input bad_char,
                  input last_of_run, output ready);
endinterface

FILE: src/calc_language_tokenizer.sv
// Streaming tokenizer for a small calculator language.
// in_i carries one source byte per word (char_in), or an end mark when
// end_of_input is set. out_o carries tokens: kind, start offset, length,
// error code, offending byte and last_of_run, which flags the final token
// caused by one input word. A byte may yield zero, one or two tokens.
// A byte is registered in the input stage, then lexed into a four-word
// result queue once the queue has room for two words; its tokens are then
// presented on out_o from the queue head. Throughput is one byte per cycle
// while the queue has room for two words; bytes that yield two tokens are
// limited by the one token per cycle that out_o drains, so the queue sets
// the sustained rate.
// When the receiver stalls, the queue fills and in_i.ready drops once fewer
// than two slots are free with a byte already waiting; nothing is lost.
// After an error token every later word is consumed with no output until
// reset. Reset (rst_ni low, asynchronous) returns the lexer to idle with
// stream offset zero and empties the input stage and the queue.
module calc_language_tokenizer #(
  parameter int unsigned MaxTokenLen = clt_pkg::MaxTokenLenDef,
  parameter int unsigned PosBits     = clt_pkg::PosBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  clt_in_if.sink           in_i,
  clt_out_if.source        out_o
);

  logic           in_vld_q, in_vld_d;
  logic [7:0]     char_q;
  logic           eoi_q;
  logic           room2;
  logic           fire;
  logic           in_acc;
  clt_pkg::push_t push;
  clt_pkg::tok_t  head;

  // Drain the input stage once the queue can take two words
  assign fire       = in_vld_q && room2;
  assign in_i.ready = !in_vld_q || room2;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc)    in_vld_d = 1'b1;
    else if (fire) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= in_i.char_in;
      eoi_q  <= in_i.end_of_input;
    end
  end

  clt_lex_core #(
    .MaxTokenLen (MaxTokenLen),
    .PosBits     (PosBits)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (char_q),
    .eoi_i  (eoi_q),
    .push_o (push)
  );

  clt_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (out_o.valid),
    .head_o  (head),
    .pop_i   (out_o.ready)
  );

  // Present the head word
  assign out_o.token_kind   = head.kind;
  assign out_o.token_start  = head.start;
  assign out_o.token_length = head.length;
  assign out_o.error_code   = head.err;
  assign out_o.bad_char     = head.bad;
  assign out_o.last_of_run  = head.last;

endmodule

FILE: src/clt_lex_core.sv
module clt_lex_core #(
  parameter int unsigned MaxTokenLen = clt_pkg::MaxTokenLenDef,
  parameter int unsigned PosBits     = clt_pkg::PosBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      char_i,
  input  logic            eoi_i,
  output clt_pkg::push_t  push_o
);

  localparam int unsigned LenW = $clog2(MaxTokenLen + 1);

  typedef enum logic [2:0] {
    ModeIdle, ModeInt, ModePoint, ModeFrac, ModeLetter, ModeIdent, ModeHalt
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [7:0]         held_q, held_d;
  logic [LenW-1:0]    run_len_q, run_len_d;
  logic [PosBits-1:0] run_start_q, run_start_d;
  logic [PosBits-1:0] spos_q, spos_d;

  logic [PosBits+31:0] spos_ext, rstart_ext;
  logic [LenW+7:0]     len_ext;
  logic [31:0]         spos32, rstart32;
  logic [7:0]          len8;

  logic is_digit, is_lower, is_space;
  logic is_op;
  logic [3:0] op_kind;
  logic ext_ok;

  logic            a_v, b_v;
  clt_pkg::tok_t   a_tok, b_tok;
  logic [3:0]      flush_kind, kw_kind;
  logic            flush_has;
  logic            want_ext, do_idle;
  mode_e           ext_mode;

  // Narrow or widen positions and lengths to the port widths
  assign spos_ext   = {32'd0, spos_q};
  assign rstart_ext = {32'd0, run_start_q};
  assign len_ext    = {8'd0, run_len_q};
  assign spos32     = spos_ext[31:0];
  assign rstart32   = rstart_ext[31:0];
  assign len8       = len_ext[7:0];

  // Classify the byte
  assign is_digit = (char_i >= clt_pkg::Ch0) && (char_i <= clt_pkg::Ch9);
  assign is_lower = (char_i >= clt_pkg::ChA) && (char_i <= clt_pkg::ChZ);
  assign is_space = (char_i == clt_pkg::ChSpace) ||
                    ((char_i >= clt_pkg::ChTab) && (char_i <= clt_pkg::ChCr));
  assign ext_ok   = run_len_q < LenW'(MaxTokenLen);

  always_comb begin
    is_op   = 1'b1;
    op_kind = clt_pkg::KindAssign;
    case (char_i)
      clt_pkg::ChAssign: op_kind = clt_pkg::KindAssign;
      clt_pkg::ChPlus:   op_kind = clt_pkg::KindPlus;
      clt_pkg::ChMinus:  op_kind = clt_pkg::KindMinus;
      clt_pkg::ChMul:    op_kind = clt_pkg::KindMul;
      clt_pkg::ChDiv:    op_kind = clt_pkg::KindDiv;
      default:           is_op = 1'b0;
    endcase
  end

  // Pending token that a closing byte flushes
  always_comb begin
    flush_has  = 1'b1;
    flush_kind = clt_pkg::KindIdent;
    unique case (mode_q)
      ModeInt:               flush_kind = clt_pkg::KindInt;
      ModeFrac:              flush_kind = clt_pkg::KindFloat;
      ModeLetter, ModeIdent: flush_kind = clt_pkg::KindIdent;
      default:               flush_has  = 1'b0;
    endcase
  end

  // Keyword for a lone letter
  always_comb begin
    case (held_q)
      clt_pkg::ChF: kw_kind = clt_pkg::KindFdecl;
      clt_pkg::ChI: kw_kind = clt_pkg::KindIdecl;
      clt_pkg::ChP: kw_kind = clt_pkg::KindPrint;
      default:      kw_kind = clt_pkg::KindIdent;
    endcase
  end

  // Mode update and result words for one source word
  always_comb begin
    mode_d      = mode_q;
    held_d      = held_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    spos_d      = spos_q;
    a_v         = 1'b0;
    b_v         = 1'b0;
    a_tok       = clt_pkg::make_tok(flush_kind, rstart32, len8, clt_pkg::ErrNone, 8'd0);
    b_tok       = '0;
    want_ext    = 1'b0;
    ext_mode    = mode_q;
    do_idle     = 1'b0;

    if (fire_i && (mode_q != ModeHalt)) begin
      if (eoi_i) begin
        if (mode_q == ModePoint) begin
          b_v    = 1'b1;
          b_tok  = clt_pkg::make_tok(clt_pkg::KindError, spos32, 8'd0,
                                     clt_pkg::ErrPoint, 8'd0);
          mode_d = ModeHalt;
        end else begin
          a_v    = flush_has;
          b_v    = 1'b1;
          b_tok  = clt_pkg::make_tok(clt_pkg::KindEnd, spos32, 8'd0,
                                     clt_pkg::ErrNone, 8'd0);
          mode_d = ModeIdle;
        end
      end else begin
        spos_d = spos_q + 1'b1;
        unique case (mode_q)
          ModeInt: begin
            if (is_digit) begin
              want_ext = 1'b1;
            end else if (char_i == clt_pkg::ChPoint) begin
              want_ext = 1'b1;
              ext_mode = ModePoint;
            end else begin
              do_idle = 1'b1;
            end
          end
          ModePoint: begin
            if (is_digit) begin
              want_ext = 1'b1;
              ext_mode = ModeFrac;
            end else begin
              b_v    = 1'b1;
              b_tok  = clt_pkg::make_tok(clt_pkg::KindError, spos32, 8'd0,
                                         clt_pkg::ErrPoint, char_i);
              mode_d = ModeHalt;
            end
          end
          ModeFrac: begin
            if (is_digit) want_ext = 1'b1;
            else          do_idle  = 1'b1;
          end
          ModeLetter: begin
            if (is_space) begin
              b_v    = 1'b1;
              b_tok  = clt_pkg::make_tok(kw_kind, rstart32, 8'd1,
                                         clt_pkg::ErrNone, 8'd0);
              mode_d = ModeIdle;
            end else if (is_lower) begin
              want_ext = 1'b1;
              ext_mode = ModeIdent;
            end else begin
              do_idle = 1'b1;
            end
          end
          ModeIdent: begin
            if (is_lower) want_ext = 1'b1;
            else          do_idle  = 1'b1;
          end
          default: do_idle = 1'b1;
        endcase

        // Grow the pending token, or stop on an over-long one
        if (want_ext) begin
          if (ext_ok) begin
            run_len_d = run_len_q + 1'b1;
            mode_d    = ext_mode;
          end else begin
            b_v    = 1'b1;
            b_tok  = clt_pkg::make_tok(clt_pkg::KindError, spos32, 8'd0,
                                       clt_pkg::ErrLong, char_i);
            mode_d = ModeHalt;
          end
        end

        // Close the pending token and scan the byte afresh
        if (do_idle) begin
          a_v    = flush_has;
          mode_d = ModeIdle;
          if (is_space) begin
            mode_d = ModeIdle;
          end else if (is_digit || is_lower) begin
            mode_d      = is_digit ? ModeInt : ModeLetter;
            held_d      = char_i;
            run_start_d = spos_q;
            run_len_d   = LenW'(1);
          end else if (is_op) begin
            b_v   = 1'b1;
            b_tok = clt_pkg::make_tok(op_kind, spos32, 8'd1, clt_pkg::ErrNone, 8'd0);
          end else begin
            b_v    = 1'b1;
            b_tok  = clt_pkg::make_tok(clt_pkg::KindError, spos32, 8'd0,
                                       clt_pkg::ErrInvalid, char_i);
            mode_d = ModeHalt;
          end
        end
      end
    end

    a_tok.last = ~b_v;
    b_tok.last = 1'b1;
  end

  // Pack the words in stream order
  always_comb begin
    push_o.n  = {1'b0, a_v} + {1'b0, b_v};
    push_o.w0 = a_v ? a_tok : b_tok;
    push_o.w1 = b_tok;
  end

  // Hold lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      held_q      <= '0;
      run_len_q   <= '0;
      run_start_q <= '0;
      spos_q      <= '0;
    end else begin
      mode_q      <= mode_d;
      held_q      <= held_d;
      run_len_q   <= run_len_d;
      run_start_q <= run_start_d;
      spos_q      <= spos_d;
    end
  end

endmodule

FILE: src/clt_res_fifo.sv
module clt_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clt_pkg::push_t push_i,
  output logic           room2_o,
  output logic           valid_o,
  output clt_pkg::tok_t  head_o,
  input  logic           pop_i
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  clt_pkg::tok_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_next;
  logic            pop;

  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign room2_o = cnt_q <= CntW'(Depth - 2);
  assign pop     = pop_i && valid_o;
  assign wr_next = wr_q + 1'b1;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.n);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store up to two words a cycle
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.w0;
    if (push_i.n == 2'd2) mem_q[wr_next] <= push_i.w1;
  end

endmodule
